// File: design/npe_pkg.sv
`default_nettype none

package npe_pkg;

  // Field widths fixed by the channel formats
  localparam int OP_W  = 1;
  localparam int POS_W = 4;
  localparam int VAL_W = 16;
  localparam int CFG_W = 5;

  // Defaults for the top-level parameters
  localparam int MAX_LEN_DEF    = 16;
  localparam int VALUE_BITS_DEF = 16;

  localparam logic [CFG_W-1:0] LEN_RESET = 5'd16;

  // Operation codes
  localparam logic [OP_W-1:0] OP_WRITE   = 1'b0;
  localparam logic [OP_W-1:0] OP_ADVANCE = 1'b1;

  typedef struct packed {
    logic [OP_W-1:0]  operation;
    logic [POS_W-1:0] position;
    logic [VAL_W-1:0] value;
  } in_item_t;

  typedef struct packed {
    logic [POS_W-1:0] element_index;
    logic [VAL_W-1:0] element_value;
    logic             last_of_run;
    logic             exhausted;
  } out_item_t;

  typedef logic [CFG_W-1:0] cfg_item_t;

  typedef enum logic [3:0] {
    ST_IDLE,
    ST_ASC_PRIME,
    ST_ASC,
    ST_LARGER,
    ST_SWAP_A,
    ST_SWAP_B,
    ST_REV_RI,
    ST_REV_RJ,
    ST_REV_WI,
    ST_REV_WJ,
    ST_EMIT_RD,
    ST_EMIT_LD
  } npe_state_t;

endpackage

`default_nettype wire

// File: design/npe_stream_if.sv
`default_nettype none

interface npe_stream_if #(
  parameter type payload_t = logic
);
  logic     valid;
  logic     ready;
  payload_t payload;

  modport source (output valid, output payload, input ready);
  modport sink (input valid, input payload, output ready);
endinterface

`default_nettype wire

// File: design/next_permutation_engine_core.sv
`default_nettype none
// Operation: a write beat goes straight into the sequence store. An advance runs the ascent
//   scan, the larger-element scan, the swap, the suffix reversal (read both, write both per
//   pair) and the emit of each entry (read, then load the output register, held while the sink
//   stalls); every step is paced by the single read and single write port of the sequence store.
// Throughput: one item at a time; the input is not ready until the last result is loaded.
// Reset: sequencer idle, output empty, length_in_use = 16; store contents undefined until written.

module next_permutation_engine_core #(
  parameter int MAX_LEN    = npe_pkg::MAX_LEN_DEF,
  parameter int VALUE_BITS = npe_pkg::VALUE_BITS_DEF
) (
  input wire logic      clk,
  input wire logic      rst_n,
  npe_stream_if.sink    in_if,
  npe_stream_if.source  out_if,
  npe_stream_if.sink    cfg_if
);

  localparam int IDX_W = $clog2(MAX_LEN);
  localparam int LEN_W = $clog2(MAX_LEN + 1);

  npe_pkg::npe_state_t state_r, state_nxt;

  logic [npe_pkg::CFG_W-1:0] len_r;
  logic [LEN_W-1:0]          n_r, n_nxt, n_eff;
  logic [IDX_W-1:0]          ptr_r, ptr_nxt;   // scan pointer, then upper reversal index
  logic [IDX_W-1:0]          lo_r, lo_nxt;     // ascent position, then lower reversal index
  logic [IDX_W-1:0]          k_r, k_nxt;       // emit counter
  logic [VALUE_BITS-1:0]     vhold_r, vhold_nxt;
  logic [VALUE_BITS-1:0]     vb_r, vb_nxt;
  logic                      exh_r, exh_nxt;

  logic                      out_valid_r, out_valid_nxt;
  npe_pkg::out_item_t        out_item_r, out_item_nxt;

  logic                      mem_we, mem_re;
  logic [IDX_W-1:0]          mem_waddr, mem_raddr;
  logic [VALUE_BITS-1:0]     mem_wdata, rd_data;

  logic [VALUE_BITS-1:0]     cmp_lhs, cmp_rhs;
  logic                      cmp_lt;

  logic                      in_fire, pos_ok, out_free, last_hit, larger_hit;
  logic [IDX_W-1:0]          last_idx;

  // Sequence store: one write and one registered read per cycle
  npe_store #(
    .DEPTH (MAX_LEN),
    .WIDTH (VALUE_BITS)
  ) u_store (
    .clk   (clk),
    .we    (mem_we),
    .waddr (mem_waddr),
    .wdata (mem_wdata),
    .re    (mem_re),
    .raddr (mem_raddr),
    .rdata (rd_data)
  );

  // Handshakes: input only while idle, configuration always taken
  assign in_if.ready  = (state_r == npe_pkg::ST_IDLE);
  assign cfg_if.ready = 1'b1;
  assign in_fire      = in_if.valid && in_if.ready;

  assign out_if.valid   = out_valid_r;
  assign out_if.payload = out_item_r;
  assign out_free       = !out_valid_r || out_if.ready;

  // Clamp the configured length to the store depth
  assign n_eff  = (32'(len_r) > 32'(MAX_LEN)) ? LEN_W'(MAX_LEN) : LEN_W'(len_r);
  assign pos_ok = 32'(in_if.payload.position) < 32'(MAX_LEN);

  assign last_idx = IDX_W'(n_r - LEN_W'(1));
  assign last_hit = (LEN_W'(k_r) + LEN_W'(1)) == n_r;

  // Shared comparator: the ascent scan tests seq[i] < seq[i+1], the larger-element
  // scan tests seq[a] < seq[j]
  always_comb begin
    if (state_r == npe_pkg::ST_LARGER) begin
      cmp_lhs = vhold_r;
      cmp_rhs = rd_data;
    end else begin
      cmp_lhs = rd_data;
      cmp_rhs = vhold_r;
    end
  end
  assign cmp_lt = cmp_lhs < cmp_rhs;

  // The entry just after the ascent is always larger; stop there at the latest
  assign larger_hit = cmp_lt || (ptr_r == lo_r + IDX_W'(1));

  // Next state
  always_comb begin
    state_nxt = state_r;
    unique case (state_r)
      npe_pkg::ST_IDLE: begin
        if (in_fire && in_if.payload.operation == npe_pkg::OP_ADVANCE) begin
          if (n_eff == LEN_W'(0)) begin
            state_nxt = npe_pkg::ST_IDLE;
          end else if (n_eff == LEN_W'(1)) begin
            state_nxt = npe_pkg::ST_EMIT_RD;
          end else begin
            state_nxt = npe_pkg::ST_ASC_PRIME;
          end
        end
      end
      npe_pkg::ST_ASC_PRIME: begin
        state_nxt = npe_pkg::ST_ASC;
      end
      npe_pkg::ST_ASC: begin
        if (cmp_lt) begin
          state_nxt = npe_pkg::ST_LARGER;
        end else if (ptr_r == IDX_W'(0)) begin
          state_nxt = npe_pkg::ST_EMIT_RD;
        end
      end
      npe_pkg::ST_LARGER: begin
        if (larger_hit) begin
          state_nxt = npe_pkg::ST_SWAP_A;
        end
      end
      npe_pkg::ST_SWAP_A: begin
        state_nxt = npe_pkg::ST_SWAP_B;
      end
      npe_pkg::ST_SWAP_B: begin
        if (lo_r + IDX_W'(1) < last_idx) begin
          state_nxt = npe_pkg::ST_REV_RI;
        end else begin
          state_nxt = npe_pkg::ST_EMIT_RD;
        end
      end
      npe_pkg::ST_REV_RI: begin
        state_nxt = npe_pkg::ST_REV_RJ;
      end
      npe_pkg::ST_REV_RJ: begin
        state_nxt = npe_pkg::ST_REV_WI;
      end
      npe_pkg::ST_REV_WI: begin
        state_nxt = npe_pkg::ST_REV_WJ;
      end
      npe_pkg::ST_REV_WJ: begin
        if (lo_r + IDX_W'(1) < ptr_r - IDX_W'(1)) begin
          state_nxt = npe_pkg::ST_REV_RI;
        end else begin
          state_nxt = npe_pkg::ST_EMIT_RD;
        end
      end
      npe_pkg::ST_EMIT_RD: begin
        if (out_free) begin
          state_nxt = npe_pkg::ST_EMIT_LD;
        end
      end
      npe_pkg::ST_EMIT_LD: begin
        if (last_hit) begin
          state_nxt = npe_pkg::ST_IDLE;
        end else begin
          state_nxt = npe_pkg::ST_EMIT_RD;
        end
      end
      default: begin
        state_nxt = npe_pkg::ST_IDLE;
      end
    endcase
  end

  // Datapath and store control
  always_comb begin
    mem_we       = 1'b0;
    mem_waddr    = lo_r;
    mem_wdata    = vb_r;
    mem_re       = 1'b0;
    mem_raddr    = ptr_r;
    n_nxt        = n_r;
    ptr_nxt      = ptr_r;
    lo_nxt       = lo_r;
    k_nxt        = k_r;
    vhold_nxt    = vhold_r;
    vb_nxt       = vb_r;
    exh_nxt      = exh_r;
    out_item_nxt = out_item_r;
    out_valid_nxt = out_valid_r && !out_if.ready;

    unique case (state_r)
      npe_pkg::ST_IDLE: begin
        if (in_fire) begin
          if (in_if.payload.operation == npe_pkg::OP_WRITE) begin
            // Drop writes beyond the store
            mem_we    = pos_ok;
            mem_waddr = IDX_W'(in_if.payload.position);
            mem_wdata = VALUE_BITS'(in_if.payload.value);
          end else begin
            n_nxt     = n_eff;
            k_nxt     = '0;
            exh_nxt   = n_eff < LEN_W'(2);
            mem_re    = 1'b1;
            mem_raddr = IDX_W'(n_eff - LEN_W'(1));
            ptr_nxt   = IDX_W'(n_eff - LEN_W'(1));
          end
        end
      end
      npe_pkg::ST_ASC_PRIME: begin
        vhold_nxt = rd_data;
        mem_re    = 1'b1;
        mem_raddr = ptr_r - IDX_W'(1);
        ptr_nxt   = ptr_r - IDX_W'(1);
      end
      npe_pkg::ST_ASC: begin
        if (cmp_lt) begin
          lo_nxt    = ptr_r;
          vhold_nxt = rd_data;
          mem_re    = 1'b1;
          mem_raddr = last_idx;
          ptr_nxt   = last_idx;
        end else if (ptr_r == IDX_W'(0)) begin
          exh_nxt = 1'b1;
        end else begin
          vhold_nxt = rd_data;
          mem_re    = 1'b1;
          mem_raddr = ptr_r - IDX_W'(1);
          ptr_nxt   = ptr_r - IDX_W'(1);
        end
      end
      npe_pkg::ST_LARGER: begin
        if (larger_hit) begin
          vb_nxt = rd_data;
        end else begin
          mem_re    = 1'b1;
          mem_raddr = ptr_r - IDX_W'(1);
          ptr_nxt   = ptr_r - IDX_W'(1);
        end
      end
      npe_pkg::ST_SWAP_A: begin
        mem_we    = 1'b1;
        mem_waddr = lo_r;
        mem_wdata = vb_r;
      end
      npe_pkg::ST_SWAP_B: begin
        mem_we    = 1'b1;
        mem_waddr = ptr_r;
        mem_wdata = vhold_r;
        lo_nxt    = lo_r + IDX_W'(1);
        ptr_nxt   = last_idx;
      end
      npe_pkg::ST_REV_RI: begin
        mem_re    = 1'b1;
        mem_raddr = lo_r;
      end
      npe_pkg::ST_REV_RJ: begin
        mem_re    = 1'b1;
        mem_raddr = ptr_r;
        vhold_nxt = rd_data;
      end
      npe_pkg::ST_REV_WI: begin
        mem_we    = 1'b1;
        mem_waddr = lo_r;
        mem_wdata = rd_data;
      end
      npe_pkg::ST_REV_WJ: begin
        mem_we    = 1'b1;
        mem_waddr = ptr_r;
        mem_wdata = vhold_r;
        lo_nxt    = lo_r + IDX_W'(1);
        ptr_nxt   = ptr_r - IDX_W'(1);
      end
      npe_pkg::ST_EMIT_RD: begin
        if (out_free) begin
          mem_re    = 1'b1;
          mem_raddr = k_r;
        end
      end
      npe_pkg::ST_EMIT_LD: begin
        // Output register is free here: the read was issued only when it would be
        out_valid_nxt              = 1'b1;
        out_item_nxt.element_index = npe_pkg::POS_W'(k_r);
        out_item_nxt.element_value = npe_pkg::VAL_W'(rd_data);
        out_item_nxt.last_of_run   = last_hit;
        out_item_nxt.exhausted     = exh_r;
        k_nxt                      = k_r + IDX_W'(1);
      end
      default: begin
        mem_we = 1'b0;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= npe_pkg::ST_IDLE;
      out_valid_r <= 1'b0;
      len_r       <= npe_pkg::LEN_RESET;
    end else begin
      state_r     <= state_nxt;
      out_valid_r <= out_valid_nxt;
      if (cfg_if.valid && cfg_if.ready) begin
        len_r <= cfg_if.payload;
      end
    end
  end

  always_ff @(posedge clk) begin
    n_r        <= n_nxt;
    ptr_r      <= ptr_nxt;
    lo_r       <= lo_nxt;
    k_r        <= k_nxt;
    vhold_r    <= vhold_nxt;
    vb_r       <= vb_nxt;
    exh_r      <= exh_nxt;
    out_item_r <= out_item_nxt;
  end

`ifndef SYNTHESIS
  a_write_no_result: assert property (@(posedge clk) disable iff (!rst_n)
    (in_fire && in_if.payload.operation == npe_pkg::OP_WRITE && !out_valid_r)
      |=> !out_valid_r)
    else $error("write beat produced a result beat");

  a_larger_above_ascent: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == npe_pkg::ST_LARGER) |-> (ptr_r > lo_r))
    else $error("larger-element scan passed the ascent");

  a_reverse_order: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == npe_pkg::ST_REV_RI) |-> (lo_r < ptr_r))
    else $error("suffix reversal indices crossed");

  a_last_ends_run: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == npe_pkg::ST_EMIT_LD && last_hit)
      |=> (state_r == npe_pkg::ST_IDLE && out_valid_r && out_item_r.last_of_run))
    else $error("final beat did not close the run");
`endif

endmodule

`default_nettype wire

// File: design/npe_store.sv
`default_nettype none

module npe_store #(
  parameter int DEPTH = npe_pkg::MAX_LEN_DEF,
  parameter int WIDTH = npe_pkg::VALUE_BITS_DEF,
  localparam int ADDR_W = $clog2(DEPTH)
) (
  input  wire logic              clk,
  input  wire logic              we,
  input  wire logic [ADDR_W-1:0] waddr,
  input  wire logic [WIDTH-1:0]  wdata,
  input  wire logic              re,
  input  wire logic [ADDR_W-1:0] raddr,
  output logic      [WIDTH-1:0]  rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
  end

  // Registered read, hold data between reads
  always_ff @(posedge clk) begin
    if (re) begin
      rdata <= mem[raddr];
    end
  end

endmodule

`default_nettype wire

// File: verif/next_permutation_engine_core_tb.sv
`default_nettype none

module next_permutation_engine_core_tb;
  timeunit 1ns;
  timeprecision 1ps;

  import npe_pkg::*;

  localparam int MAX_LEN = MAX_LEN_DEF;
  // Cycles to let the engine finish work that leaves no result beat behind
  // (a write, or an advance over zero entries) before the length is changed.
  localparam int SETTLE_CYCLES = 120;
  // Cycles without any accepted beat on any channel before giving up.
  localparam int STALL_LIMIT = 4000;
  localparam int TOTAL_ITEMS = 175;

  // Predicts the beats of every advance and matches them against the output.
  class perm_scoreboard;
    logic [VAL_W-1:0] seq_entries [MAX_LEN];
    logic [CFG_W-1:0] length_reg;
    out_item_t        awaited_beats [$];
    int               failures;

    function new();
      length_reg = LEN_RESET;
      failures = 0;
      foreach (seq_entries[k]) seq_entries[k] = '0;
    endfunction

    function void load_length(cfg_item_t v);
      length_reg = v;
    endfunction

    function int pending();
      return awaited_beats.size();
    endfunction

    // Step the first n entries to their next lexicographic order in place.
    // Return 0, leaving the entries alone, when they are already the last one.
    function bit permute_forward(int n);
      int k, pivot, larger_at, lo, hi;
      logic [VAL_W-1:0] held;
      pivot = -1;
      larger_at = -1;
      if (n < 2) return 1'b0;
      for (k = n - 1; k > 0 && pivot < 0; k--)
        if (seq_entries[k-1] < seq_entries[k]) pivot = k - 1;
      if (pivot < 0) return 1'b0;
      // The ascent guarantees a larger entry to the right of the pivot.
      for (k = n - 1; k > pivot && larger_at < 0; k--)
        if (seq_entries[pivot] < seq_entries[k]) larger_at = k;
      held = seq_entries[pivot];
      seq_entries[pivot] = seq_entries[larger_at];
      seq_entries[larger_at] = held;
      lo = pivot + 1;
      hi = n - 1;
      while (lo < hi) begin
        held = seq_entries[lo];
        seq_entries[lo] = seq_entries[hi];
        seq_entries[hi] = held;
        lo++;
        hi--;
      end
      return 1'b1;
    endfunction

    function void note_item(in_item_t item);
      int n, k;
      bit moved;
      out_item_t beat;
      if (item.operation == OP_WRITE) begin
        seq_entries[item.position] = item.value;
        return;
      end
      n = (length_reg > MAX_LEN) ? MAX_LEN : int'(length_reg);
      moved = permute_forward(n);
      for (k = 0; k < n; k++) begin
        beat.element_index = k[POS_W-1:0];
        beat.element_value = seq_entries[k];
        beat.last_of_run   = (k == n - 1);
        beat.exhausted     = !moved;
        awaited_beats.push_back(beat);
      end
    endfunction

    function void check_beat(out_item_t got);
      out_item_t want;
      if (awaited_beats.size() == 0) begin
        $error("result beat with nothing awaited: element_index %0d element_value %0d",
               got.element_index, got.element_value);
        failures++;
        return;
      end
      want = awaited_beats.pop_front();
      if (got.element_index !== want.element_index) begin
        $error("element_index: expected %0d, actual %0d", want.element_index, got.element_index);
        failures++;
      end
      if (got.element_value !== want.element_value) begin
        $error("element_value: expected %0d, actual %0d", want.element_value, got.element_value);
        failures++;
      end
      if (got.last_of_run !== want.last_of_run) begin
        $error("last_of_run: expected %0d, actual %0d", want.last_of_run, got.last_of_run);
        failures++;
      end
      if (got.exhausted !== want.exhausted) begin
        $error("exhausted: expected %0d, actual %0d", want.exhausted, got.exhausted);
        failures++;
      end
    endfunction
  endclass

  logic clk;
  logic rst_n;

  npe_stream_if #(.payload_t(in_item_t))  in_ch ();
  npe_stream_if #(.payload_t(out_item_t)) out_ch ();
  npe_stream_if #(.payload_t(cfg_item_t)) cfg_ch ();

  next_permutation_engine_core dut (
    .clk    (clk),
    .rst_n  (rst_n),
    .in_if  (in_ch),
    .out_if (out_ch),
    .cfg_if (cfg_ch)
  );

  perm_scoreboard sb = new();

  int send_idle_pct = 25;
  int recv_idle_pct = 72;
  int items_sent    = 0;
  int quiet_cycles  = 0;
  // Positions written so far: an advance never reaches an entry left unwritten.
  bit written [MAX_LEN];

  initial begin
    clk = 1'b0;
    forever #1 clk = ~clk;
  end

  // Receiver: decide readiness afresh at every falling edge.
  initial begin
    out_ch.ready = 1'b0;
    forever begin
      @(negedge clk);
      out_ch.ready <= ($urandom_range(0, 99) >= recv_idle_pct);
    end
  end

  // Monitor: sample every channel at the rising edge, feed the scoreboard and
  // keep the watchdog on any cycle in which no beat moves.
  always @(posedge clk) begin
    if (rst_n) begin
      if (in_ch.valid && in_ch.ready) sb.note_item(in_ch.payload);
      if (out_ch.valid && out_ch.ready) sb.check_beat(out_ch.payload);
      if (cfg_ch.valid && cfg_ch.ready) sb.load_length(cfg_ch.payload);
      if ((in_ch.valid && in_ch.ready) || (out_ch.valid && out_ch.ready) ||
          (cfg_ch.valid && cfg_ch.ready))
        quiet_cycles = 0;
      else
        quiet_cycles++;
      if (quiet_cycles >= STALL_LIMIT) begin
        $display("status: fail");
        $finish;
      end
    end
  end

  // Offer one item and hold it until accepted. Enter and leave at a falling edge.
  task automatic send_item(input logic [OP_W-1:0] op, input logic [POS_W-1:0] pos,
                           input logic [VAL_W-1:0] val);
    in_item_t item;
    item.operation = op;
    item.position  = pos;
    item.value     = val;
    // Three idling phases: busy sender with a stalling receiver, the other
    // way round, then both flat out.
    if (items_sent < 70) begin
      send_idle_pct = 25;
      recv_idle_pct = 72;
    end else if (items_sent < 140) begin
      send_idle_pct = 72;
      recv_idle_pct = 25;
    end else begin
      send_idle_pct = 0;
      recv_idle_pct = 0;
    end
    if ($urandom_range(0, 99) < send_idle_pct) begin
      in_ch.valid <= 1'b0;
      do @(negedge clk); while ($urandom_range(0, 99) < send_idle_pct);
    end
    in_ch.valid   <= 1'b1;
    in_ch.payload <= item;
    do @(posedge clk); while (!in_ch.ready);
    @(negedge clk);
    items_sent++;
  endtask

  task automatic write_entry(input int pos, input logic [VAL_W-1:0] val);
    written[pos] = 1'b1;
    send_item(OP_WRITE, pos[POS_W-1:0], val);
  endtask

  // Position and value ride along as noise: the engine must ignore them.
  task automatic advance_seq();
    send_item(OP_ADVANCE, POS_W'($urandom_range(0, 15)), VAL_W'($urandom_range(0, 65535)));
  endtask

  // Drop valid, wait for every awaited beat, then give the engine time to go idle.
  task automatic settle();
    in_ch.valid <= 1'b0;
    while (sb.pending() != 0) @(negedge clk);
    repeat (SETTLE_CYCLES) @(negedge clk);
  endtask

  task automatic set_length(input int len);
    settle();
    cfg_ch.valid   <= 1'b1;
    cfg_ch.payload <= len[CFG_W-1:0];
    do @(posedge clk); while (!cfg_ch.ready);
    @(negedge clk);
    cfg_ch.valid <= 1'b0;
  endtask

  initial begin
    int seg_len, n, k, mode, adv_count, pick;
    bit reuse;
    logic [VAL_W-1:0] v;

    in_ch.valid    = 1'b0;
    in_ch.payload  = '0;
    cfg_ch.valid   = 1'b0;
    cfg_ch.payload = '0;
    rst_n          = 1'b0;
    repeat (8) @(posedge clk);
    @(negedge clk);
    rst_n <= 1'b1;

    // Directed: zero length gives no beats at all.
    set_length(0);
    advance_seq();
    // Length one: a single beat, last and exhausted.
    set_length(1);
    write_entry(0, 16'hFFFF);
    advance_seq();
    // Three entries: one step forward, then already descending.
    set_length(3);
    write_entry(1, 16'h0000);
    write_entry(2, 16'h8000);
    advance_seq();
    advance_seq();
    // Repeated values.
    set_length(4);
    write_entry(0, 16'd5);
    write_entry(1, 16'd5);
    write_entry(2, 16'd7);
    write_entry(3, 16'd7);
    advance_seq();
    // Length above the store size saturates to the full sixteen entries.
    set_length(31);
    for (k = 4; k < MAX_LEN; k++) write_entry(k, VAL_W'(1) << k);
    advance_seq();

    // Random: mostly well-formed runs of a fresh length, a fresh fill and a
    // string of advances, with stray writes mixed in.
    while (items_sent < TOTAL_ITEMS) begin
      pick = $urandom_range(0, 99);
      if (pick < 8) seg_len = 0;
      else if (pick < 16) seg_len = 1;
      else if (pick < 70) seg_len = $urandom_range(2, 6);
      else if (pick < 84) seg_len = $urandom_range(7, 15);
      else if (pick < 93) seg_len = 16;
      else seg_len = $urandom_range(17, 31);
      set_length(seg_len);
      n = (seg_len > MAX_LEN) ? MAX_LEN : seg_len;

      // Carry on from the current contents now and then, where all are written.
      reuse = ($urandom_range(0, 2) == 0);
      for (k = 0; k < n; k++) if (!written[k]) reuse = 1'b0;
      mode = $urandom_range(0, 3);
      if (!reuse) begin
        for (k = 0; k < n; k++) begin
          case (mode)
            0: v = VAL_W'($urandom_range(0, 65535));
            1: v = VAL_W'($urandom_range(0, 3));
            2: v = VAL_W'(k);
            default: v = VAL_W'(n - 1 - k);
          endcase
          write_entry(k, v);
        end
      end

      // Short sequences get long runs so that they walk into exhaustion.
      if (n <= 4) adv_count = $urandom_range(1, 8);
      else if (n < MAX_LEN) adv_count = $urandom_range(1, 4);
      else adv_count = $urandom_range(1, 2);
      for (k = 0; k < adv_count; k++) begin
        if ($urandom_range(0, 99) < 15)
          write_entry($urandom_range(0, MAX_LEN - 1), VAL_W'($urandom_range(0, 65535)));
        advance_seq();
      end
    end

    settle();
    if (sb.failures == 0)
      $display("status: pass");
    else
      $display("status: fail");
    $finish;
  end

endmodule

`default_nettype wire
